### rtl/ciss_pkg.sv
`default_nettype none

package ciss_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_PATTERN_LO     = 3'd0;
   localparam logic [2:0] CSR_PATTERN_MID_LO = 3'd1;
   localparam logic [2:0] CSR_PATTERN_MID_HI = 3'd2;
   localparam logic [2:0] CSR_PATTERN_HI     = 3'd3;
   localparam logic [2:0] CSR_PATTERN_LENGTH = 3'd4;
   localparam logic [2:0] CSR_START_INDEX    = 3'd5;

   // Fixed widths of the register file.
   localparam int PATTERN_REG_BYTES = 32;
   localparam int LENGTH_W          = 6;
   localparam int START_W           = 32;
   localparam int MATCH_W           = 32;
   localparam int EFF_LEN_W         = 7;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Letters a to z are folded to A to Z; all other bytes pass unchanged.
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // Configuration as seen by the front and the back.
   typedef struct packed {
      logic [8*PATTERN_REG_BYTES-1:0] pattern;
      logic [LENGTH_W-1:0]            pattern_length;
      logic [START_W-1:0]             start_index;
   } cfg_type;

   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= LOWER_A && b <= LOWER_Z) begin
         r = b - CASE_DELTA;
      end
      return r;
   endfunction

   // Pattern length in use: zero counts as one, and it is capped at max_len.
   function automatic logic [EFF_LEN_W-1:0] effective_length(
      input logic [LENGTH_W-1:0] raw,
      input int                  max_len
   );
      logic [EFF_LEN_W-1:0] n;
      n = EFF_LEN_W'(raw);
      if (raw == '0) begin
         n = EFF_LEN_W'(1);
      end
      if (int'(n) > max_len) begin
         n = EFF_LEN_W'(max_len);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### rtl/ciss_front.sv
`default_nettype none

module ciss_front
   import ciss_pkg::*;
#(
   parameter int PATTERN_MAX = 32
) (
   input  wire cfg_type                cfg,
   input  wire logic [7:0]             text_byte,
   output logic      [PATTERN_MAX-1:0] eq_vec
);

   logic [7:0]           text_folded;
   logic [EFF_LEN_W-1:0] eff_len;

   assign text_folded = fold_case(text_byte);
   assign eff_len     = effective_length(cfg.pattern_length, PATTERN_MAX);

   // One comparator per pattern position; positions past the length never match.
   // Positions past the register file hold a zero byte.
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cmp
      logic [7:0] pat_byte;
      if (i < PATTERN_REG_BYTES) begin : g_reg
         assign pat_byte = fold_case(cfg.pattern[8*i +: 8]);
      end else begin : g_zero
         assign pat_byte = 8'h00;
      end
      assign eq_vec[i] = (pat_byte == text_folded) && (EFF_LEN_W'(i) < eff_len);
   end

endmodule

`default_nettype wire

### rtl/ciss_queue.sv
`default_nettype none

module ciss_queue
   import ciss_pkg::*;
#(
   parameter int WIDTH = 33
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates; the depth is a power of two so pointers wrap.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue popped while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count past depth");

endmodule

`default_nettype wire

### rtl/ciss_back.sv
`default_nettype none

module ciss_back
   import ciss_pkg::*;
#(
   parameter int PATTERN_MAX   = 32,
   parameter int POSITION_BITS = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   q_empty,
   input  wire logic [PATTERN_MAX-1:0] q_eq,
   input  wire logic                   q_last,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_found,
   output logic      [MATCH_W-1:0]     rsp_match_start
);

   localparam int SUM_W = START_W + 2;

   logic [PATTERN_MAX-1:0]   pm_ff, pm_in;
   logic [POSITION_BITS-1:0] count_ff, count_in;
   logic                     done_ff, done_in;
   logic                     valid_ff, valid_in;
   logic                     found_ff, found_in;
   logic [MATCH_W-1:0]       start_ff, start_in;

   logic [EFF_LEN_W-1:0]     eff_len;
   logic [EFF_LEN_W-1:0]     len_m1;
   logic [PATTERN_MAX-1:0]   top_mask;
   logic [PATTERN_MAX-1:0]   pm_next;
   logic                     hit;
   logic                     count_sat;
   logic [SUM_W-1:0]         sum;
   logic                     sum_over;
   logic [POSITION_BITS-1:0] pos;

   assign eff_len = effective_length(cfg.pattern_length, PATTERN_MAX);
   assign len_m1  = eff_len - EFF_LEN_W'(1);

   // Marks the pattern's last position; a set bit there is a full match.
   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         top_mask[i] = (EFF_LEN_W'(i) == len_m1);
      end
   end

   // Shift-and step for the byte at the head of the queue.
   assign pm_next = ((pm_ff << 1) | PATTERN_MAX'(1)) & q_eq;
   assign hit     = |(pm_next & top_mask);

   // Start of the match, saturated at the top of the position range.
   assign count_sat = &count_ff;
   assign sum       = SUM_W'(cfg.start_index) + SUM_W'(count_ff) - SUM_W'(len_m1);
   assign sum_over  = |sum[SUM_W-1:POSITION_BITS];
   assign pos       = (count_sat || sum_over) ? '1 : sum[POSITION_BITS-1:0];

   // A byte is taken whenever the output register is free or drains this cycle.
   assign q_pop = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      pm_in    = pm_ff;
      count_in = count_ff;
      done_in  = done_ff;
      valid_in = valid_ff && !rsp_ready;
      found_in = found_ff;
      start_in = start_ff;
      if (q_pop) begin
         if (!done_ff) begin
            pm_in = pm_next;
            if (hit) begin
               valid_in = 1'b1;
               found_in = 1'b1;
               start_in = MATCH_W'(pos);
               done_in  = 1'b1;
            end else if (q_last) begin
               valid_in = 1'b1;
               found_in = 1'b0;
               start_in = '0;
            end
            if (!count_sat) begin
               count_in = count_ff + POSITION_BITS'(1);
            end
         end
         // The window ends: the next byte starts a fresh search.
         if (q_last) begin
            pm_in    = '0;
            count_in = '0;
            done_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff    <= '0;
         count_ff <= '0;
         done_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pm_ff    <= pm_in;
         count_ff <= count_in;
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      start_ff <= start_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_match_start = start_ff;

   a_done_after_hit: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !done_ff && hit && !q_last) |=> done_ff)
      else $error("search not closed after a match");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !found_ff) |-> (start_ff == '0))
      else $error("miss result carries a position");
   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |-> !q_pop)
      else $error("byte taken while the result is stalled");

endmodule

`default_nettype wire

### rtl/case_insensitive_substring_search_core.sv
`default_nettype none

// Case-insensitive substring search over a byte stream.
// The req channel carries one text byte per item in req_tdata; req_tlast marks the
// last byte of a window. The rsp channel gives at most one item per window: at the
// first match (rsp_tuser found = 1, rsp_tdata the match start plus start_index,
// saturated), or at the window's last byte with found = 0 and a zero position.
// Bytes after a match are consumed without a result until the window ends.
// The csr channel writes the pattern words, the pattern length and start_index; it
// is always ready; the user must write it only while no search is in flight, which
// the block does not enforce. Throughput is one byte per cycle while rsp does not
// stall, set by the shift-and update in the back end. Each byte passes the queue,
// and its result the output register. A four-entry queue separates the comparator
// front end from the back end, so req_tready stays high through short rsp stalls
// and drops only once the queue fills. Reset clears the search state, the queue and
// the output, and returns the registers to zero pattern, length 1 and start index 0.
module case_insensitive_substring_search_core
   import ciss_pkg::*;
#(
   parameter int PATTERN_MAX   = 32,
   parameter int POSITION_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Text input.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,        // [7:0] text_byte
   input  wire logic        req_tlast,        // window_end
   // Search results.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,        // [31:0] match_start
   output logic             rsp_tuser,        // [0] found
   // Register writes.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int ENTRY_W = PATTERN_MAX + 1;

   cfg_type              cfg_ff;
   logic [PATTERN_MAX-1:0] eq_vec;
   logic                   q_full;
   logic                   q_empty;
   logic                   q_pop;
   logic                   push;
   logic [ENTRY_W-1:0]     q_out;

   // Register file.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern        <= '0;
         cfg_ff.pattern_length <= LENGTH_W'(1);
         cfg_ff.start_index    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_LO:     cfg_ff.pattern[63:0]    <= csr_data;
            CSR_PATTERN_MID_LO: cfg_ff.pattern[127:64]  <= csr_data;
            CSR_PATTERN_MID_HI: cfg_ff.pattern[191:128] <= csr_data;
            CSR_PATTERN_HI:     cfg_ff.pattern[255:192] <= csr_data;
            CSR_PATTERN_LENGTH: cfg_ff.pattern_length   <= csr_data[LENGTH_W-1:0];
            CSR_START_INDEX:    cfg_ff.start_index      <= csr_data[START_W-1:0];
            default: ;
         endcase
      end
   end

   // Front end: fold and compare each accepted byte against every pattern position.
   ciss_front #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_front (
      .cfg       (cfg_ff),
      .text_byte (req_tdata),
      .eq_vec    (eq_vec)
   );

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   ciss_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({req_tlast, eq_vec}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // Back end: match vector, position counter and result register.
   ciss_back #(
      .PATTERN_MAX  (PATTERN_MAX),
      .POSITION_BITS(POSITION_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_eq            (q_out[PATTERN_MAX-1:0]),
      .q_last          (q_out[PATTERN_MAX]),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_found       (rsp_tuser),
      .rsp_match_start (rsp_tdata)
   );

endmodule

`default_nettype wire

### dv/case_insensitive_substring_search_core_tb.sv
`timescale 1ns / 100ps

module case_insensitive_substring_search_core_tb;
   import ciss_pkg::*;

   localparam int TEXT_TARGET   = 1050;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 3000;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_PCT      = 14;

   // One search result: found flag and match start, offset by start_index.
   typedef struct packed {
      logic        found;
      logic [31:0] start;
   } match_rec_type;

   // Mirrors the pattern registers and the shift-and search state, and keeps
   // the results the block still owes in order.
   class match_scoreboard;
      logic [255:0]  pattern;
      logic [5:0]    length_reg;
      logic [31:0]   start_index;
      logic [31:0]   partial;
      logic [31:0]   byte_count;
      bit            done;
      match_rec_type expected_matches[$];
      int            errors;

      function new();
         pattern     = '0;
         length_reg  = 6'd1;
         start_index = '0;
         partial     = '0;
         byte_count  = '0;
         done        = 1'b0;
         errors      = 0;
      endfunction

      static function logic [7:0] upcase(input logic [7:0] b);
         logic [7:0] r;
         r = b;
         if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
         end
         return r;
      endfunction

      function void write_reg(input logic [2:0] idx, input logic [63:0] value);
         case (idx)
            CSR_PATTERN_LO:     pattern[63:0]    = value;
            CSR_PATTERN_MID_LO: pattern[127:64]  = value;
            CSR_PATTERN_MID_HI: pattern[191:128] = value;
            CSR_PATTERN_HI:     pattern[255:192] = value;
            CSR_PATTERN_LENGTH: length_reg       = value[5:0];
            CSR_START_INDEX:    start_index      = value[31:0];
            default: ;
         endcase
      endfunction

      // Advances the search by one accepted text byte.
      function void note_text_byte(input logic [7:0] text, input logic last);
         logic [7:0]    b;
         logic [63:0]   eq;
         logic [63:0]   pm;
         logic [63:0]   mask;
         logic [63:0]   pos;
         match_rec_type rec;
         int            len;
         int            i;
         b   = upcase(text);
         len = (length_reg == 0) ? 1 : ((length_reg > 32) ? 32 : int'(length_reg));
         if (!done) begin
            eq = '0;
            for (i = 0; i < len; i++) begin
               if (upcase(pattern[i*8 +: 8]) == b) begin
                  eq[i] = 1'b1;
               end
            end
            mask    = (64'd1 << len) - 64'd1;
            pm      = (({32'd0, partial} << 1) | 64'd1) & eq & mask;
            partial = pm[31:0];
            if (pm[len-1]) begin
               // The reported start saturates, and so does the byte counter.
               if (byte_count == 32'hFFFF_FFFF) begin
                  pos = 64'hFFFF_FFFF;
               end else begin
                  pos = {32'd0, start_index} + {32'd0, byte_count} - 64'(len - 1);
                  if (pos > 64'hFFFF_FFFF) begin
                     pos = 64'hFFFF_FFFF;
                  end
               end
               rec.found = 1'b1;
               rec.start = pos[31:0];
               expected_matches.push_back(rec);
               done = 1'b1;
            end else if (last) begin
               rec.found = 1'b0;
               rec.start = '0;
               expected_matches.push_back(rec);
            end
            if (byte_count != 32'hFFFF_FFFF) begin
               byte_count++;
            end
         end
         // Every window end starts a fresh search.
         if (last) begin
            partial    = '0;
            byte_count = '0;
            done       = 1'b0;
         end
      endfunction

      function void check_match(input logic found, input logic [31:0] start);
         match_rec_type want;
         if (expected_matches.size() == 0) begin
            $error("result with none pending: found %0b match_start %0h", found, start);
            errors++;
            return;
         end
         want = expected_matches.pop_front();
         if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            errors++;
         end
         if (start !== want.start) begin
            $error("match_start: expected %0h, actual %0h", want.start, start);
            errors++;
         end
      endfunction

      function int pending();
         return expected_matches.size();
      endfunction
   endclass

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index   = '0;
   logic [63:0] csr_data    = '0;

   match_scoreboard sb;
   logic [7:0]      pat [32];
   int              eff_len;
   int              text_sent;
   int              quiet_cycles;
   int              rsp_hold_left;
   bit              steady;

   case_insensitive_substring_search_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Handshakes are sampled with their pre-edge values; the watchdog counts
   // cycles in which no item moves on any channel.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_text_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_match(rsp_tuser, rsp_tdata);
         end
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_data);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[case_insensitive_substring_search_core] ERROR");
            $finish;
         end
      end
   end

   // Result receiver: random stalls, a long hold-off on request, none when steady.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_left--;
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic [7:0] vary_case(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (is_letter(b) && $urandom_range(1) != 0) begin
         r = b ^ 8'h20;
      end
      return r;
   endfunction

   // Pattern bytes lean toward letters so that case folding is exercised.
   function automatic logic [7:0] pick_pattern_byte();
      logic [7:0] b;
      case ($urandom_range(3))
         0:       b = 8'h41 + 8'($urandom_range(25));
         1:       b = 8'h61 + 8'($urandom_range(25));
         2:       b = 8'($urandom_range(255));
         default: b = ($urandom_range(1) != 0) ? 8'h00 : 8'hFF;
      endcase
      return b;
   endfunction

   // Noise draws half its bytes from the pattern to build partial matches.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      if ($urandom_range(1) != 0) begin
         b = vary_case(pat[$urandom_range(eff_len - 1)]);
      end else begin
         b = 8'($urandom_range(255));
      end
      return b;
   endfunction

   function automatic logic [31:0] pick_start();
      logic [31:0] s;
      case ($urandom_range(3))
         0:       s = '0;
         1:       s = 32'hFFFF_FFFF;
         2:       s = 32'hFFFF_FF00 | 32'($urandom_range(255));
         default: s = $urandom;
      endcase
      return s;
   endfunction

   // Offers one text item, idling first at random, and waits for acceptance.
   // Valid stays high afterwards so that back-to-back items need no extra edge.
   task automatic send_text(input logic [7:0] b, input logic last);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Stops the text stream, waits for every owed result, then lets the
   // pipeline empty of bytes that cause no result.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_pattern(input logic [5:0] len_raw, input logic [31:0] start,
                               input bit all_ones);
      logic [255:0] words;
      int           k;
      for (k = 0; k < 32; k++) begin
         pat[k]          = all_ones ? 8'hFF : pick_pattern_byte();
         words[k*8 +: 8] = pat[k];
      end
      eff_len = (len_raw == 0) ? 1 : ((len_raw > 32) ? 32 : int'(len_raw));
      write_csr(CSR_PATTERN_LO, words[63:0]);
      write_csr(CSR_PATTERN_MID_LO, words[127:64]);
      write_csr(CSR_PATTERN_MID_HI, words[191:128]);
      write_csr(CSR_PATTERN_HI, words[255:192]);
      write_csr(CSR_PATTERN_LENGTH, 64'(len_raw));
      write_csr(CSR_START_INDEX, 64'(start));
      csr_valid <= 1'b0;
   endtask

   // Most windows carry the pattern in random case, often after a false start;
   // the rest are noise only.
   task automatic send_windows(input int budget);
      logic [7:0] win[$];
      int         used;
      int         part;
      int         k;
      used = 0;
      while (used < budget) begin
         win.delete();
         if ($urandom_range(9) < 6) begin
            repeat ($urandom_range(6)) win.push_back(noise_byte());
            if (eff_len > 1 && $urandom_range(2) == 0) begin
               part = $urandom_range(1, eff_len - 1);
               for (k = 0; k < part; k++) begin
                  win.push_back(vary_case(pat[k]));
               end
            end
            for (k = 0; k < eff_len; k++) begin
               win.push_back(vary_case(pat[k]));
            end
            if ($urandom_range(7) != 0) begin
               repeat ($urandom_range(1, 5)) win.push_back(noise_byte());
            end
         end else begin
            repeat ($urandom_range(1, 12)) win.push_back(noise_byte());
         end
         for (k = 0; k < win.size(); k++) begin
            send_text(win[k], k == win.size() - 1);
         end
         used += win.size();
      end
      text_sent += used;
   endtask

   initial begin
      int          phase;
      logic [5:0]  len_raw;
      logic [31:0] start;
      sb            = new();
      text_sent     = 0;
      quiet_cycles  = 0;
      rsp_hold_left = 0;
      steady        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a zero byte of length one, start index zero.
      send_text(8'h00, 1'b0);
      send_text(8'h41, 1'b1);
      send_text(8'hFF, 1'b1);
      send_text(8'h7A, 1'b0);
      send_text(8'h00, 1'b1);
      wait_idle();

      // Mixed-case pattern near the top of the position range; the second
      // window has a false start and a saturated position.
      write_csr(CSR_PATTERN_LO, 64'h0000_0000_0063_4261);
      write_csr(CSR_PATTERN_LENGTH, 64'd3);
      write_csr(CSR_START_INDEX, 64'hFFFF_FFFE);
      csr_valid <= 1'b0;
      send_text(8'h41, 1'b0);
      send_text(8'h62, 1'b0);
      send_text(8'h43, 1'b0);
      send_text(8'h40, 1'b1);
      send_text(8'h78, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(8'h42, 1'b0);
      send_text(8'h63, 1'b1);
      wait_idle();

      // Length zero counts as one; bytes just outside the letter ranges.
      write_csr(CSR_PATTERN_LO, 64'h61);
      write_csr(CSR_PATTERN_LENGTH, 64'd0);
      write_csr(CSR_START_INDEX, 64'd0);
      csr_valid <= 1'b0;
      send_text(8'h60, 1'b0);
      send_text(8'h7B, 1'b0);
      send_text(8'h40, 1'b0);
      send_text(8'h5B, 1'b0);
      send_text(8'h41, 1'b1);

      // Random phases, each with its own pattern, length and start index.
      phase = 0;
      while (text_sent < TEXT_TARGET) begin
         wait_idle();
         case (phase)
            0:       len_raw = 6'd1;
            1:       len_raw = 6'd63;
            2:       len_raw = 6'd0;
            3:       len_raw = 6'd32;
            4:       len_raw = 6'd33;
            default: len_raw = ($urandom_range(3) == 0) ? 6'($urandom_range(63))
                                                      : 6'($urandom_range(2, 12));
         endcase
         start = (phase == 1) ? 32'hFFFF_FFFF : ((phase == 3) ? 32'd0 : pick_start());
         load_pattern(len_raw, start, phase == 1);
         steady = (phase == 3);
         if (phase == 0) begin
            // Short windows each owe a result, so the block backs up here.
            rsp_hold_left = HOLD_CYCLES;
         end
         send_windows((phase == 3) ? 200 : $urandom_range(40, 120));
         phase++;
      end
      steady = 1'b0;
      wait_idle();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("[case_insensitive_substring_search_core] OK");
      end else begin
         $display("[case_insensitive_substring_search_core] ERROR");
      end
      $finish;
   end

endmodule
